/* rtl/toeq_pkg.sv */
// Shared types, field widths and codes for the time-ordered event queue.
`default_nettype none

package toeq_pkg;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 64;

   localparam int unsigned TIME_W      = 48;
   localparam int unsigned KIND_W      = 4;
   localparam int unsigned ID_W        = 8;
   localparam int unsigned PACKET_W    = 32;
   localparam int unsigned OCC_W       = 7;
   localparam int unsigned ACTION_W    = 2;
   localparam int unsigned STATUS_W    = 2;
   localparam int unsigned REQ_TDATA_W = 104;
   localparam int unsigned RSP_TDATA_W = 112;

   typedef enum logic [ACTION_W-1:0] {
      ACT_SORTED     = 2'd0,
      ACT_AFTER_HEAD = 2'd1,
      ACT_POP        = 2'd2
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic [TIME_W-1:0]   ev_time;
      logic [KIND_W-1:0]   kind;
      logic [ID_W-1:0]     sender;
      logic [ID_W-1:0]     receiver;
      logic [PACKET_W-1:0] packet;
   } entry_type;

endpackage

`default_nettype wire

/* rtl/toeq_slot_ram.sv */
// Event slot memory: one write port, one registered read port.
`default_nettype none

module toeq_slot_ram #(
   parameter int unsigned DEPTH = toeq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  toeq_pkg::entry_type       wr_data,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr,
   output toeq_pkg::entry_type       rd_data_ff
);
   import toeq_pkg::*;

   entry_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

`default_nettype wire

/* rtl/time_ordered_event_queue_core.sv */
// Top level of the time-ordered event queue.
//
// Holds up to QUEUE_DEPTH events in a circular buffer in one slot memory, with a copy
// of the head event in flops. One transaction is worked on at a time and each gives
// exactly one response carrying the status, the head after the operation and the
// occupancy. A refused insert, a pop of an empty queue, the unused action code, an
// insert into an empty queue, a sorted insert that lands at the head and a pop that
// empties the queue go straight from idle to the response state. Any other pop reads
// the new head from the slot memory; an insert after the head first writes the head
// one slot back and then the new event into the old head slot. Any other sorted insert
// scans the slot memory one entry per cycle. One that lands at the tail is written
// there when the scan ends; one that lands in front of a later event stops the scan
// there and then moves the entries behind it one slot up, one per cycle through the
// single read and write port, before writing the new event. The response register
// lets a finished response wait while the core returns to idle; a response still
// waiting there holds the core in its last state.
`default_nettype none

module time_ordered_event_queue_core #(
   parameter int unsigned QUEUE_DEPTH = toeq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // event_time, event_kind, sender_id, receiver_id, packet_id, zero pad
   input  logic [toeq_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // action
   input  logic [toeq_pkg::ACTION_W-1:0]      req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // head_valid, head_time, head_kind, head_sender, head_receiver, head_packet,
   // occupancy, zero pad
   output logic [toeq_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // status
   output logic [toeq_pkg::STATUS_W-1:0]      rsp_tuser
);
   import toeq_pkg::*;

   localparam int unsigned ADDR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned SUM_W  = CNT_W + 1;
   localparam int unsigned PAD_W  = RSP_TDATA_W - (1 + TIME_W + KIND_W + 2*ID_W
                                                   + PACKET_W + OCC_W);

   typedef enum logic [7:0] {
      ST_IDLE    = 8'b0000_0001,
      ST_SCAN    = 8'b0000_0010,
      ST_SHIFT   = 8'b0000_0100,
      ST_IAH     = 8'b0000_1000,
      ST_IAH_NEW = 8'b0001_0000,
      ST_POP_RD  = 8'b0010_0000,
      ST_POP_LD  = 8'b0100_0000,
      ST_RESP    = 8'b1000_0000
   } state_type;

   // physical slot of logical position offs behind the head
   function automatic logic [ADDR_W-1:0] phys(input logic [ADDR_W-1:0] base,
                                              input logic [CNT_W-1:0]  offs);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(offs);
      if (sum >= SUM_W'(QUEUE_DEPTH)) begin
         sum = sum - SUM_W'(QUEUE_DEPTH);
      end
      return sum[ADDR_W-1:0];
   endfunction

   // control
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] head_ptr_ff, head_ptr_in;
   logic              cmp_valid_ff, cmp_valid_in;
   logic              sh_go_ff, sh_go_in;
   logic              wr_valid_ff, wr_valid_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // payload
   entry_type                head_ff, head_in;
   entry_type                new_ff, new_in;
   status_type               status_ff, status_in;
   logic [CNT_W-1:0]         scan_ff, scan_in;
   logic [CNT_W-1:0]         cmp_idx_ff, cmp_idx_in;
   logic [CNT_W-1:0]         pos_ff, pos_in;
   logic [CNT_W-1:0]         sh_ff, sh_in;
   logic [CNT_W-1:0]         wr_idx_ff, wr_idx_in;
   logic [RSP_TDATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [STATUS_W-1:0]      rsp_user_ff, rsp_user_in;

   // memory port
   logic              mem_wr_en;
   logic [ADDR_W-1:0] mem_wr_addr;
   entry_type         mem_wr_data;
   logic [ADDR_W-1:0] mem_rd_addr;
   entry_type         mem_rd_data;

   entry_type         in_entry;
   entry_type         rsp_head;
   logic              rsp_head_valid;
   logic              q_full;
   logic              q_empty;
   logic              scan_hit;
   logic [ADDR_W-1:0] head_dec;

   toeq_slot_ram #(
      .DEPTH (QUEUE_DEPTH)
   ) u_slot_ram (
      .clock      (clock),
      .wr_en      (mem_wr_en),
      .wr_addr    (mem_wr_addr),
      .wr_data    (mem_wr_data),
      .rd_addr    (mem_rd_addr),
      .rd_data_ff (mem_rd_data)
   );

   assign in_entry.ev_time  = req_tdata[47:0];
   assign in_entry.kind     = req_tdata[51:48];
   assign in_entry.sender   = req_tdata[59:52];
   assign in_entry.receiver = req_tdata[67:60];
   assign in_entry.packet   = req_tdata[99:68];

   assign q_full   = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign q_empty  = (count_ff == '0);
   assign head_dec = (head_ptr_ff == '0) ? ADDR_W'(QUEUE_DEPTH - 1) : head_ptr_ff - 1'b1;
   assign scan_hit = cmp_valid_ff && (mem_rd_data.ev_time > new_ff.ev_time);

   assign rsp_head_valid = !q_empty;
   assign rsp_head       = rsp_head_valid ? head_ff : '0;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      head_ptr_in  = head_ptr_ff;
      cmp_valid_in = cmp_valid_ff;
      sh_go_in     = sh_go_ff;
      wr_valid_in  = wr_valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      head_in      = head_ff;
      new_in       = new_ff;
      status_in    = status_ff;
      scan_in      = scan_ff;
      cmp_idx_in   = cmp_idx_ff;
      pos_in       = pos_ff;
      sh_in        = sh_ff;
      wr_idx_in    = wr_idx_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = head_ptr_ff;
      mem_wr_data  = new_ff;
      mem_rd_addr  = head_ptr_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               new_in    = in_entry;
               status_in = STATUS_DONE;
               state_in  = ST_RESP;
               case (req_tuser)
                  ACT_SORTED: begin
                     if (q_full) begin
                        status_in = STATUS_FULL;
                     end else if (q_empty) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_data = in_entry;
                        head_in     = in_entry;
                        count_in    = count_ff + 1'b1;
                     end else if (head_ff.ev_time > in_entry.ev_time) begin
                        // new head: grow the ring backward
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = head_dec;
                        mem_wr_data = in_entry;
                        head_ptr_in = head_dec;
                        head_in     = in_entry;
                        count_in    = count_ff + 1'b1;
                     end else begin
                        scan_in      = CNT_W'(1);
                        cmp_valid_in = 1'b0;
                        state_in     = ST_SCAN;
                     end
                  end
                  ACT_AFTER_HEAD: begin
                     if (q_full) begin
                        status_in = STATUS_FULL;
                     end else if (q_empty) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_data = in_entry;
                        head_in     = in_entry;
                        count_in    = count_ff + 1'b1;
                     end else begin
                        state_in = ST_IAH;
                     end
                  end
                  ACT_POP: begin
                     if (q_empty) begin
                        status_in = STATUS_EMPTY;
                     end else begin
                        count_in    = count_ff - 1'b1;
                        head_ptr_in = phys(head_ptr_ff, CNT_W'(1));
                        if (count_ff != CNT_W'(1)) begin
                           state_in = ST_POP_RD;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end

         ST_SCAN: begin
            // read of position scan_ff; compare of cmp_idx_ff sees its data
            mem_rd_addr = phys(head_ptr_ff, scan_ff);
            if (scan_hit) begin
               pos_in      = cmp_idx_ff;
               sh_in       = count_ff - 1'b1;
               sh_go_in    = 1'b1;
               wr_valid_in = 1'b0;
               state_in    = ST_SHIFT;
            end else if (scan_ff == count_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = phys(head_ptr_ff, count_ff);
               count_in    = count_ff + 1'b1;
               state_in    = ST_RESP;
            end else begin
               cmp_valid_in = 1'b1;
               cmp_idx_in   = scan_ff;
               scan_in      = scan_ff + 1'b1;
            end
         end

         ST_SHIFT: begin
            // read position sh_ff, write previous read one position up
            mem_rd_addr = phys(head_ptr_ff, sh_ff);
            if (wr_valid_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = phys(head_ptr_ff, wr_idx_ff + 1'b1);
               mem_wr_data = mem_rd_data;
            end
            if (sh_go_ff) begin
               wr_valid_in = 1'b1;
               wr_idx_in   = sh_ff;
               if (sh_ff == pos_ff) begin
                  sh_go_in = 1'b0;
               end else begin
                  sh_in = sh_ff - 1'b1;
               end
            end else begin
               wr_valid_in = 1'b0;
            end
            if (!sh_go_ff && !wr_valid_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = phys(head_ptr_ff, pos_ff);
               mem_wr_data = new_ff;
               count_in    = count_ff + 1'b1;
               state_in    = ST_RESP;
            end
         end

         ST_IAH: begin
            // head copy moves one slot back, its old slot takes the new event
            mem_wr_en   = 1'b1;
            mem_wr_addr = head_dec;
            mem_wr_data = head_ff;
            head_ptr_in = head_dec;
            state_in    = ST_IAH_NEW;
         end

         ST_IAH_NEW: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = phys(head_ptr_ff, CNT_W'(1));
            count_in    = count_ff + 1'b1;
            state_in    = ST_RESP;
         end

         ST_POP_RD: begin
            mem_rd_addr = head_ptr_ff;
            state_in    = ST_POP_LD;
         end

         ST_POP_LD: begin
            head_in  = mem_rd_data;
            state_in = ST_RESP;
         end

         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = status_ff;
               rsp_data_in  = {PAD_W'(0), OCC_W'(count_ff), rsp_head.packet,
                               rsp_head.receiver, rsp_head.sender, rsp_head.kind,
                               rsp_head.ev_time, rsp_head_valid};
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         head_ptr_ff  <= '0;
         cmp_valid_ff <= 1'b0;
         sh_go_ff     <= 1'b0;
         wr_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ptr_ff  <= head_ptr_in;
         cmp_valid_ff <= cmp_valid_in;
         sh_go_ff     <= sh_go_in;
         wr_valid_ff  <= wr_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff     <= head_in;
      new_ff      <= new_in;
      status_ff   <= status_in;
      scan_ff     <= scan_in;
      cmp_idx_ff  <= cmp_idx_in;
      pos_ff      <= pos_in;
      sh_ff       <= sh_in;
      wr_idx_ff   <= wr_idx_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

endmodule

`default_nettype wire

/* rtl/toeq_checker.sv */
// Port-level assertions for the event queue core, bound to the top level.
`default_nettype none

module toeq_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [toeq_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [toeq_pkg::STATUS_W-1:0]    rsp_tuser
);
   import toeq_pkg::*;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // one transaction in flight
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   a_head_vs_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[0] == (rsp_tdata[107:101] != '0))
      else $error("head_valid disagrees with occupancy");

   a_empty_head_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[100:1] == '0)
      else $error("empty queue reports a head event");

   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STATUS_EMPTY |-> !rsp_tdata[0] && rsp_tdata[107:101] == '0)
      else $error("empty status on a nonempty queue");

endmodule

bind time_ordered_event_queue_core toeq_checker u_toeq_checker (.*);

`default_nettype wire

/* tb/sv/tb.sv */
// Self-checking testbench for the time-ordered event queue: random and directed traffic.
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import toeq_pkg::*;

   localparam int DEPTH = QUEUE_DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 600000;
   localparam int RANDOM_ITEMS = 1000;
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic                head_valid;
      entry_type           head;
      logic [OCC_W-1:0]    occupancy;
   } head_report;

   // Tracks the timeline and the head reports still owed by the block.
   class timeline_tracker;
      entry_type  slots[DEPTH];
      int         held;
      head_report expected_heads[$];
      int         mismatches, checked, inserted, refused, empty_pops, peak;

      function void note_request(logic [ACTION_W-1:0] act, entry_type ev);
         head_report r;
         int pos;
         r.status = STATUS_DONE;
         if (act == ACT_SORTED || act == ACT_AFTER_HEAD) begin
            if (held >= DEPTH) begin
               r.status = STATUS_FULL;
               refused++;
            end else begin
               pos = 0;
               if (act == ACT_SORTED) begin
                  // equal times go behind, keeping arrival order
                  while (pos < held && slots[pos].ev_time <= ev.ev_time) pos++;
               end else begin
                  pos = (held == 0) ? 0 : 1;
               end
               for (int i = held; i > pos; i--) slots[i] = slots[i-1];
               slots[pos] = ev;
               held++;
               inserted++;
               if (held > peak) peak = held;
            end
         end else if (act == ACT_POP) begin
            if (held == 0) begin
               r.status = STATUS_EMPTY;
               empty_pops++;
            end else begin
               for (int i = 1; i < held; i++) slots[i-1] = slots[i];
               held--;
            end
         end
         r.head_valid = (held > 0);
         r.head = (held > 0) ? slots[0] : '0;
         r.occupancy = held[OCC_W-1:0];
         expected_heads.push_back(r);
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_response(head_report got);
         head_report want;
         if (expected_heads.size() == 0) begin
            $error("response with no transaction outstanding");
            mismatches++;
            return;
         end
         want = expected_heads.pop_front();
         checked++;
         compare_field("status", 64'(want.status), 64'(got.status));
         compare_field("head_valid", 64'(want.head_valid), 64'(got.head_valid));
         compare_field("head_time", 64'(want.head.ev_time), 64'(got.head.ev_time));
         compare_field("head_kind", 64'(want.head.kind), 64'(got.head.kind));
         compare_field("head_sender", 64'(want.head.sender), 64'(got.head.sender));
         compare_field("head_receiver", 64'(want.head.receiver), 64'(got.head.receiver));
         compare_field("head_packet", 64'(want.head.packet), 64'(got.head.packet));
         compare_field("occupancy", 64'(want.occupancy), 64'(got.occupancy));
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_TDATA_W-1:0]   req_tdata;
   logic [ACTION_W-1:0]      req_tuser;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_TDATA_W-1:0]   rsp_tdata;
   logic [STATUS_W-1:0]      rsp_tuser;

   timeline_tracker tracker;
   logic            no_idle;
   int              cycles;

   time_ordered_event_queue_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic entry_type make_event(logic [TIME_W-1:0] t, logic [KIND_W-1:0] k,
                                            logic [ID_W-1:0] s, logic [ID_W-1:0] r,
                                            logic [PACKET_W-1:0] p);
      entry_type ev;
      ev.ev_time = t;
      ev.kind = k;
      ev.sender = s;
      ev.receiver = r;
      ev.packet = p;
      return ev;
   endfunction

   // narrow times make plenty of ties
   function automatic entry_type random_event(bit narrow);
      logic [TIME_W-1:0] t;
      t[47:16] = $urandom;
      t[15:0] = 16'($urandom);
      if (narrow) begin
         t = TIME_W'($urandom_range(0, 7));
      end else begin
         case ($urandom_range(0, 2))
            0: t = TIME_W'($urandom_range(0, 15));
            1: t = t >> $urandom_range(0, 40);
            default: ;
         endcase
      end
      return make_event(t, KIND_W'($urandom_range(0, 15)), ID_W'($urandom), ID_W'($urandom),
                        $urandom);
   endfunction

   // Leaves tvalid high on return; the next call decides whether it drops.
   task automatic send_item(logic [ACTION_W-1:0] act, entry_type ev);
      if (!no_idle && $urandom_range(0, 99) < 7) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 80)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {4'b0, ev.packet, ev.receiver, ev.sender, ev.kind, ev.ev_time};
      do @(posedge clock); while (!req_tready);
      tracker.note_request(act, ev);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (tracker.expected_heads.size() != 0) @(posedge clock);
   endtask

   // response side
   initial begin
      head_report got;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.status = rsp_tuser;
            got.head_valid = rsp_tdata[0];
            got.head.ev_time = rsp_tdata[48:1];
            got.head.kind = rsp_tdata[52:49];
            got.head.sender = rsp_tdata[60:53];
            got.head.receiver = rsp_tdata[68:61];
            got.head.packet = rsp_tdata[100:69];
            got.occupancy = rsp_tdata[107:101];
            tracker.check_response(got);
         end
         rsp_tready <= no_idle || ($urandom_range(0, 99) >= 7);
      end
   end

   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Verification failed");
      $finish;
   end

   initial begin
      entry_type zero_ev;
      int sent, phase, n;
      logic [ACTION_W-1:0] act;
      tracker = new();
      zero_ev = '0;
      no_idle = 1'b0;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= ACT_SORTED;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: empty cases, field extremes, ties, after-head, unused code
      send_item(ACT_POP, zero_ev);
      send_item(ACT_UNUSED, zero_ev);
      send_item(ACT_AFTER_HEAD, make_event(48'd5, 4'd3, 8'd1, 8'd2, 32'd3));
      send_item(ACT_POP, zero_ev);
      send_item(ACT_SORTED, zero_ev);
      send_item(ACT_SORTED, make_event('1, 4'hf, 8'hff, 8'hff, 32'hffff_ffff));
      send_item(ACT_SORTED, make_event('1, 4'd8, 8'h55, 8'haa, 32'd1));
      send_item(ACT_SORTED, make_event('0, 4'd9, 8'haa, 8'h55, 32'd2));
      send_item(ACT_AFTER_HEAD, make_event('1, 4'd7, 8'h0f, 8'hf0, 32'h8000_0000));
      send_item(ACT_SORTED, make_event(48'd1, 4'd4, 8'd7, 8'd9, 32'h1234_5678));
      send_item(ACT_SORTED, make_event(48'h8000_0000_0000, 4'd0, 8'd0, 8'd0, 32'd4));
      send_item(ACT_UNUSED, random_event(1'b0));
      repeat (8) send_item(ACT_POP, zero_ev);
      send_item(ACT_AFTER_HEAD, random_event(1'b0));
      send_item(ACT_AFTER_HEAD, random_event(1'b0));
      wait_drained();

      sent = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         no_idle = (sent >= 300 && sent < 500);
         case (phase)
            0: begin
               // fill to capacity, then a few refused inserts
               n = $urandom_range(1, 3);
               while (tracker.held < DEPTH || n > 0) begin
                  if (tracker.held >= DEPTH) n--;
                  act = ($urandom_range(0, 9) < 8) ? ACT_SORTED : ACT_AFTER_HEAD;
                  send_item(act, random_event($urandom_range(0, 1) == 1));
                  sent++;
               end
               wait_drained();
            end
            1: begin
               // drain, then pop past empty
               n = $urandom_range(1, 2);
               while (tracker.held > 0 || n > 0) begin
                  if (tracker.held == 0) n--;
                  send_item(ACT_POP, zero_ev);
                  sent++;
               end
            end
            default: begin
               repeat ($urandom_range(20, 60)) begin
                  case ($urandom_range(0, 19))
                     0, 1, 2, 3, 4, 5, 6, 7, 8: act = ACT_SORTED;
                     9, 10: act = ACT_AFTER_HEAD;
                     19: act = ACT_UNUSED;
                     default: act = ACT_POP;
                  endcase
                  send_item(act, random_event($urandom_range(0, 2) == 0));
                  if (act != ACT_UNUSED) sent++;
               end
            end
         endcase
         phase = $urandom_range(0, 3);
      end
      no_idle = 1'b0;
      wait_drained();
      repeat (200) @(posedge clock);

      $display("Run: %0d responses checked, %0d events queued, %0d full refusals.",
               tracker.checked, tracker.inserted, tracker.refused);
      $display("     %0d pops on an empty queue, peak occupancy %0d of %0d.",
               tracker.empty_pops, tracker.peak, DEPTH);
      if (tracker.mismatches == 0 && tracker.expected_heads.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
